// ----- design/log_line_keyword_counter_macros.svh -----
// assertion macros used by the keyword counter checker
`ifndef LOG_LINE_KEYWORD_COUNTER_MACROS_SVH
`define LOG_LINE_KEYWORD_COUNTER_MACROS_SVH

// property checked on every clock edge, reset included
`define LLKC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

// property checked only while out of reset
`define LLKC_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`endif

// ----- design/llkc_pkg.sv -----
// shared constants, types and match tables of the log line keyword counter
`default_nettype none

package llkc_pkg;

    // sizing
    localparam int LINE_BUFFER_BYTES = 512;
    localparam int COUNT_WIDTH       = 32;
    localparam int LEN_W             = $clog2(LINE_BUFFER_BYTES);
    localparam int WIN_DEPTH         = 11;
    localparam int SPAN              = WIN_DEPTH + 1;
    localparam int POS_W             = $clog2(SPAN);
    localparam int NUM_WORDS         = 9;
    localparam int NUM_ANOM          = 5;
    localparam int NUM_TOTALS        = 10;
    localparam int OUT_CNT_W         = 32;
    localparam int SEV_W             = 3;

    // result item packing
    localparam int FIELD_BITS = SEV_W + NUM_ANOM + NUM_TOTALS * OUT_CNT_W;
    localparam int TDATA_W    = ((FIELD_BITS + 7) / 8) * 8;
    localparam int MASK_LSB   = SEV_W;
    localparam int TOT_LSB    = SEV_W + NUM_ANOM;

    // byte codes
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // severity classes
    localparam logic [SEV_W-1:0] LVL_NONE     = 3'd0;
    localparam logic [SEV_W-1:0] LVL_INFO     = 3'd1;
    localparam logic [SEV_W-1:0] LVL_WARNING  = 3'd2;
    localparam logic [SEV_W-1:0] LVL_ERROR    = 3'd3;
    localparam logic [SEV_W-1:0] LVL_CRITICAL = 3'd4;

    // word found flags
    localparam int W_CRITICAL = 0;
    localparam int W_ERROR    = 1;
    localparam int W_WARNING  = 2;
    localparam int W_INFO     = 3;
    localparam int W_ANOM_LSB = 4;

    // total slots
    localparam int T_LINES    = 0;
    localparam int T_ANOM_LSB = 5;

    // words right-aligned in the search span, zero bytes are don't-care
    localparam logic [SPAN*8-1:0] WORD_ROW [NUM_WORDS] = '{
        "CRITICAL", "ERROR", "WARNING", "INFO",
        "failed", "unauthorized", "attack", "denied", "timeout"
    };

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // closing line event handed to the totals bank
    typedef struct packed {
        logic                  close;
        logic [SEV_W-1:0]      sev;
        logic [NUM_ANOM-1:0]   mask;
    } close_t;

    // per-word compare of one span position, true where the byte matches the word or the word does not reach
    function automatic logic [NUM_WORDS-1:0] pos_hit(input logic [POS_W-1:0] pos,
                                                     input logic [7:0] b);
        logic [7:0]           ch;
        logic [NUM_WORDS-1:0] h;
        logic [POS_W-1:0]     rev;
        rev = POS_W'(SPAN - 1) - pos;
        for (int w = 0; w < NUM_WORDS; w++) begin
            ch   = WORD_ROW[w][rev*8 +: 8];
            h[w] = (ch == CHAR_NUL) || (ch == b);
        end
        return h;
    endfunction

    // low output bits of a total
    function automatic logic [OUT_CNT_W-1:0] out_low(input count_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[OUT_CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- design/llkc_cell.sv -----
// one window cell: holds a byte, passes it on and compares it against the words
`default_nettype none

module llkc_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      shift_en,
    input  wire logic                      clear_en,
    input  wire logic [7:0]                byte_in,
    input  wire logic [llkc_pkg::POS_W-1:0] pos,
    output logic [7:0]                     byte_out,
    output logic [llkc_pkg::NUM_WORDS-1:0] hit
);
    import llkc_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // clear on a closing byte, shift on a searched byte
    always_comb begin
        byte_next = byte_reg;
        if (clear_en) begin
            byte_next = CHAR_NUL;
        end else if (shift_en) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= CHAR_NUL;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = pos_hit(pos, byte_reg);

endmodule

`default_nettype wire

// ----- design/llkc_totals.sv -----
// bank of saturating running totals, bumped once per closed line
`default_nettype none

module llkc_totals (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire llkc_pkg::close_t    ev,
    output llkc_pkg::count_t         totals [llkc_pkg::NUM_TOTALS]
);
    import llkc_pkg::*;

    count_t                tot_reg  [NUM_TOTALS];
    count_t                tot_next [NUM_TOTALS];
    logic [NUM_TOTALS-1:0] bump;

    // which totals this line touches
    always_comb begin
        bump = '0;
        bump[T_LINES] = 1'b1;
        for (int s = 1; s < T_ANOM_LSB; s++) begin
            bump[s] = (ev.sev == SEV_W'(s));
        end
        for (int a = 0; a < NUM_ANOM; a++) begin
            bump[T_ANOM_LSB + a] = ev.mask[a];
        end
    end

    // saturating increments
    always_comb begin
        for (int i = 0; i < NUM_TOTALS; i++) begin
            tot_next[i] = tot_reg[i];
            if (ev.close && bump[i] && (tot_reg[i] != {COUNT_WIDTH{1'b1}})) begin
                tot_next[i] = tot_reg[i] + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TOTALS; i++) begin
                tot_reg[i] <= '0;
            end
        end else begin
            tot_reg <= tot_next;
        end
    end

    assign totals = tot_reg;

endmodule

`default_nettype wire

// ----- design/log_line_keyword_counter.sv -----
// log line keyword counter: top level with the cell chain and result register
//
// Input stream: one text byte per item on s_tdata, s_tlast marks end of stream
// and closes any open line after that byte. A line also closes at a newline
// byte (kept in the line) or once it holds 511 bytes.
// Result stream: one item per closed line on m_tdata, carrying the severity
// class, the anomaly word mask and the ten running totals after that line.
// Latency: the result of a closing byte shows on m_tvalid in the cycle after
// it is accepted.
// Throughput: one byte per cycle. An eleven-cell byte window shifts once per
// searched byte and all nine words are compared against it in that cycle.
// A held result holds off every byte, closing or not; s_tready drops while a
// result waits and m_tready is low.
// Reset (aresetn low, synchronous) clears the window, the line state, the
// totals and the result valid; s_tready is high from the first cycle after.
// Bytes after a zero byte of a line are counted in its length but not searched.
// Totals saturate at all ones.
`default_nettype none

module log_line_keyword_counter (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // data_byte
    input  wire logic [7:0]                    s_tdata,
    input  wire logic                          s_tlast,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // line_severity, word_hit_mask, lines_total, info_total, warning_total,
    // error_total, critical_total, failed_total, unauthorized_total,
    // attack_total, denied_total, timeout_total
    output logic [llkc_pkg::TDATA_W-1:0]       m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);
    import llkc_pkg::*;

    logic                  s_accept;
    logic                  search;
    logic                  close;
    logic [LEN_W:0]        len_inc;

    logic                  zero_seen_reg, zero_seen_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [NUM_WORDS-1:0]  words_reg, words_next;
    logic [SEV_W-1:0]      sev_reg, sev_next;
    logic [NUM_ANOM-1:0]   mask_reg, mask_next;
    logic                  m_valid_reg, m_valid_next;

    logic [7:0]            win_byte [WIN_DEPTH];
    logic [NUM_WORDS-1:0]  cell_hit [WIN_DEPTH];
    logic [NUM_WORDS-1:0]  new_hit;
    logic [NUM_WORDS-1:0]  span_hit;
    logic [SEV_W-1:0]      sev_cur;
    close_t                ev;
    count_t                totals [NUM_TOTALS];

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    // byte classification
    assign search  = !zero_seen_reg && (s_tdata != CHAR_NUL);
    assign len_inc = {1'b0, len_reg} + 1'b1;
    assign close   = (s_tdata == CHAR_NEWLINE) || s_tlast
                     || (len_inc >= (LEN_W+1)'(LINE_BUFFER_BYTES - 1));

    // window cells, oldest byte in cell zero, each takes its right neighbour
    for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
        logic [7:0] feed;
        if (i == WIN_DEPTH - 1) begin : g_tail
            assign feed = s_tdata;
        end else begin : g_mid
            assign feed = win_byte[i+1];
        end
        llkc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (s_accept && search),
            .clear_en (s_accept && close),
            .byte_in  (feed),
            .pos      (POS_W'(i)),
            .byte_out (win_byte[i]),
            .hit      (cell_hit[i])
        );
    end

    // newest span position is the incoming byte
    assign new_hit = pos_hit(POS_W'(SPAN - 1), s_tdata);

    // a word is found when every position it covers agrees
    always_comb begin
        span_hit = new_hit;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            span_hit = span_hit & cell_hit[i];
        end
    end

    assign words_next = words_reg | (search ? span_hit : '0);

    // severity by priority
    always_comb begin
        if (words_next[W_CRITICAL]) begin
            sev_cur = LVL_CRITICAL;
        end else if (words_next[W_ERROR]) begin
            sev_cur = LVL_ERROR;
        end else if (words_next[W_WARNING]) begin
            sev_cur = LVL_WARNING;
        end else if (words_next[W_INFO]) begin
            sev_cur = LVL_INFO;
        end else begin
            sev_cur = LVL_NONE;
        end
    end

    assign ev.close = s_accept && close;
    assign ev.sev   = sev_cur;
    assign ev.mask  = words_next[W_ANOM_LSB +: NUM_ANOM];

    // line state and result register
    always_comb begin
        zero_seen_next = zero_seen_reg;
        len_next       = len_reg;
        sev_next       = sev_reg;
        mask_next      = mask_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        if (s_accept) begin
            if (close) begin
                zero_seen_next = 1'b0;
                len_next       = '0;
                sev_next       = ev.sev;
                mask_next      = ev.mask;
                m_valid_next   = 1'b1;
            end else begin
                zero_seen_next = zero_seen_reg || (s_tdata == CHAR_NUL);
                len_next       = len_inc[LEN_W-1:0];
            end
        end
    end

    logic [NUM_WORDS-1:0] words_upd;
    assign words_upd = !s_accept ? words_reg : (close ? '0 : words_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_seen_reg <= 1'b0;
            len_reg       <= '0;
            words_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            zero_seen_reg <= zero_seen_next;
            len_reg       <= len_next;
            words_reg     <= words_upd;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sev_reg  <= sev_next;
        mask_reg <= mask_next;
    end

    llkc_totals u_totals (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ev      (ev),
        .totals  (totals)
    );

    // result packing, totals move only with a new result
    always_comb begin
        m_tdata = '0;
        m_tdata[SEV_W-1:0]              = sev_reg;
        m_tdata[MASK_LSB +: NUM_ANOM]   = mask_reg;
        for (int i = 0; i < NUM_TOTALS; i++) begin
            m_tdata[TOT_LSB + i*OUT_CNT_W +: OUT_CNT_W] = out_low(totals[i]);
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

// ----- design/llkc_checker.sv -----
// port-level checks of the keyword counter and their binding to the top level
`default_nettype none

`include "log_line_keyword_counter_macros.svh"

module llkc_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic [7:0]                  s_tdata,
    input wire logic                        s_tlast,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [llkc_pkg::TDATA_W-1:0] m_tdata,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready
);
    import llkc_pkg::*;

    logic s_close;
    assign s_close = s_tvalid && s_tready && (s_tlast || (s_tdata == CHAR_NEWLINE));

    // no result comes out of reset
    `LLKC_ASSERT(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")
    // a stalled result stays
    `LLKC_ASSERT_RUN(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    // a stalled result keeps its contents
    `LLKC_ASSERT_RUN(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed")
    // a newline or end of stream always gives a result next cycle
    `LLKC_ASSERT_RUN(a_close_result, s_close |=> m_tvalid, "closed line without result")
    // severity code within range
    `LLKC_ASSERT_RUN(a_sev_range, m_tvalid |-> m_tdata[SEV_W-1:0] <= LVL_CRITICAL, "bad severity")

endmodule

bind log_line_keyword_counter llkc_checker u_llkc_checker (.*);

`default_nettype wire
